// ===== rtl/snp_rx_pkg.sv =====
// ----------------------------------------------------------------------------
// snp_rx_pkg
// Shared constants and controller/datapath interface types for the SNP
// packet receiver.
// ----------------------------------------------------------------------------
package snp_rx_pkg;

	localparam int PAYLOAD_DEPTH = 64;
	localparam int PAYLOAD_AW    = $clog2(PAYLOAD_DEPTH);
	localparam int LEN_W         = 6;
	localparam int REG_IDX_W     = 2;

	localparam logic [7:0]  SYNC_S   = 8'h73;
	localparam logic [7:0]  SYNC_N   = 8'h6E;
	localparam logic [7:0]  SYNC_P   = 8'h70;
	localparam logic [15:0] SYNC_SUM = 16'(SYNC_S) + 16'(SYNC_N) + 16'(SYNC_P);

	localparam int TYPE_HAS_DATA_BIT = 7;
	localparam int TYPE_IS_BATCH_BIT = 6;
	localparam logic [LEN_W-1:0] SINGLE_LEN = 6'd4;

	localparam logic [7:0] CONFIG_BASE_RST  = 8'd0;
	localparam logic [7:0] DATA_BASE_RST    = 8'd85;
	localparam logic [7:0] COMMAND_BASE_RST = 8'd170;
	localparam logic [7:0] BAD_CODE_RST     = 8'd253;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CONFIG_BASE  = 2'd0,
		REG_DATA_BASE    = 2'd1,
		REG_COMMAND_BASE = 2'd2,
		REG_BAD_CODE     = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLASS_CONFIG  = 2'd0,
		CLASS_DATA    = 2'd1,
		CLASS_COMMAND = 2'd2
	} addr_class_t;

	typedef struct packed {
		logic             ld_sum_init;
		logic             ld_type;
		logic             ld_addr;
		logic             wr_data;
		logic             ld_csum_hi;
		logic             ld_csum_lo;
		logic             rd_mem;
		logic             ld_out;
		logic             out_last;
		logic [LEN_W-1:0] idx;
	} srx_cmd_t;

	typedef struct packed {
		logic             is_s;
		logic             is_n;
		logic             is_p;
		logic [LEN_W-1:0] type_len;
		logic [LEN_W-1:0] len;
		logic             single;
		logic             out_free;
	} srx_stat_t;

endpackage

// ===== rtl/snp_rx_dp.sv =====
// ----------------------------------------------------------------------------
// snp_rx_dp
// Datapath: configuration registers, header fields, running checksum,
// payload memory and the result output register.
// ----------------------------------------------------------------------------
module snp_rx_dp import snp_rx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic [7:0]           rx_byte,
	input  srx_cmd_t             cmd,
	output srx_stat_t            stat,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic                 status,
	output logic [7:0]           packet_type,
	output logic [7:0]           address,
	output logic [1:0]           address_class,
	output logic [LEN_W-1:0]     payload_len,
	output logic [LEN_W-1:0]     byte_index,
	output logic [7:0]           data_byte,
	output logic [15:0]          checksum,
	output logic                 last
);

	logic [7:0]       config_base_q, data_base_q, command_base_q, bad_code_q;
	logic [7:0]       type_q, addr_q;
	addr_class_t      class_q, class_d;
	logic [LEN_W-1:0] len_q, type_len;
	logic [15:0]      sum_q, rx_csum_q;
	logic [7:0]       csum_hi_q;
	logic             bad_q;
	logic [7:0]       rd_q;
	logic [7:0]       payload_mem [PAYLOAD_DEPTH];
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			config_base_q  <= CONFIG_BASE_RST;
			data_base_q    <= DATA_BASE_RST;
			command_base_q <= COMMAND_BASE_RST;
			bad_code_q     <= BAD_CODE_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_CONFIG_BASE:  config_base_q  <= cfg_data;
				REG_DATA_BASE:    data_base_q    <= cfg_data;
				REG_COMMAND_BASE: command_base_q <= cfg_data;
				REG_BAD_CODE:     bad_code_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (rx_byte >= config_base_q && rx_byte < data_base_q)
			class_d = CLASS_CONFIG;
		else if (rx_byte >= data_base_q && rx_byte < command_base_q)
			class_d = CLASS_DATA;
		else
			class_d = CLASS_COMMAND;
	end

	always_comb begin
		if (!type_q[TYPE_HAS_DATA_BIT])
			type_len = '0;
		else if (type_q[TYPE_IS_BATCH_BIT])
			type_len = {type_q[5:2], 2'b00};
		else
			type_len = SINGLE_LEN;
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_sum_init)
			sum_q <= SYNC_SUM;
		else if (cmd.ld_type || cmd.ld_addr || cmd.wr_data)
			sum_q <= sum_q + 16'(rx_byte);
		if (cmd.ld_type)
			type_q <= rx_byte;
		if (cmd.ld_addr) begin
			addr_q  <= rx_byte;
			class_q <= class_d;
			len_q   <= type_len;
		end
		if (cmd.wr_data)
			payload_mem[cmd.idx[PAYLOAD_AW-1:0]] <= rx_byte;
		if (cmd.rd_mem)
			rd_q <= payload_mem[cmd.idx[PAYLOAD_AW-1:0]];
		if (cmd.ld_csum_hi)
			csum_hi_q <= rx_byte;
		if (cmd.ld_csum_lo) begin
			rx_csum_q <= {csum_hi_q, rx_byte};
			bad_q     <= ({csum_hi_q, rx_byte} != sum_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.ld_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			if (bad_q) begin
				status        <= 1'b1;
				packet_type   <= '0;
				address       <= bad_code_q;
				address_class <= CLASS_CONFIG;
				payload_len   <= '0;
				byte_index    <= '0;
				data_byte     <= '0;
				checksum      <= SYNC_SUM + 16'(bad_code_q);
				last          <= 1'b1;
			end else begin
				status        <= 1'b0;
				packet_type   <= type_q;
				address       <= addr_q;
				address_class <= class_q;
				payload_len   <= len_q;
				byte_index    <= cmd.idx;
				data_byte     <= (len_q == '0) ? 8'd0 : rd_q;
				checksum      <= rx_csum_q;
				last          <= cmd.out_last;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.is_s     = (rx_byte == SYNC_S);
	assign stat.is_n     = (rx_byte == SYNC_N);
	assign stat.is_p     = (rx_byte == SYNC_P);
	assign stat.type_len = type_len;
	assign stat.len      = len_q;
	assign stat.single   = bad_q || (len_q == '0);
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

// ===== rtl/snp_rx_ctrl.sv =====
// ----------------------------------------------------------------------------
// snp_rx_ctrl
// Controller: sync hunt, header/data/checksum sequencing and replay of the
// stored payload into the output register.
// ----------------------------------------------------------------------------
module snp_rx_ctrl import snp_rx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  srx_stat_t stat,
	output srx_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_SYNC,
		ST_TYPE,
		ST_ADDR,
		ST_DATA,
		ST_CSUM,
		ST_FETCH,
		ST_LOAD
	} state_t;

	state_t           state_q, state_d;
	logic [LEN_W-1:0] cnt_q, cnt_d, cnt_inc;
	logic             acc;

	assign in_ready = (state_q == ST_SYNC) || (state_q == ST_TYPE) ||
	                  (state_q == ST_ADDR) || (state_q == ST_DATA) ||
	                  (state_q == ST_CSUM);
	assign acc      = in_valid && in_ready;
	assign cnt_inc  = cnt_q + 6'd1;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.idx = cnt_q;
		case (state_q)
			ST_SYNC: begin
				if (acc) begin
					case (cnt_q)
						6'd0: cnt_d = stat.is_s ? 6'd1 : 6'd0;
						6'd1: cnt_d = stat.is_n ? 6'd2 : 6'd0;
						6'd2: begin
							cnt_d = '0;
							if (stat.is_p) begin
								cmd.ld_sum_init = 1'b1;
								state_d         = ST_TYPE;
							end
						end
						default: cnt_d = '0;
					endcase
				end
			end
			ST_TYPE: begin
				if (acc) begin
					cmd.ld_type = 1'b1;
					state_d     = ST_ADDR;
				end
			end
			ST_ADDR: begin
				if (acc) begin
					cmd.ld_addr = 1'b1;
					cnt_d       = '0;
					state_d     = (stat.type_len == '0) ? ST_CSUM : ST_DATA;
				end
			end
			ST_DATA: begin
				if (acc) begin
					cmd.wr_data = 1'b1;
					if (cnt_inc == stat.len) begin
						cnt_d   = '0;
						state_d = ST_CSUM;
					end else begin
						cnt_d = cnt_inc;
					end
				end
			end
			ST_CSUM: begin
				if (acc) begin
					if (cnt_q == '0) begin
						cmd.ld_csum_hi = 1'b1;
						cnt_d          = 6'd1;
					end else begin
						cmd.ld_csum_lo = 1'b1;
						cnt_d          = '0;
						state_d        = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				cmd.rd_mem = 1'b1;
				state_d    = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.out_last = stat.single || (cnt_inc == stat.len);
				if (stat.out_free) begin
					cmd.ld_out = 1'b1;
					if (cmd.out_last) begin
						cnt_d   = '0;
						state_d = ST_SYNC;
					end else begin
						cnt_d   = cnt_inc;
						state_d = ST_FETCH;
					end
				end
			end
			default: begin
				cnt_d   = '0;
				state_d = ST_SYNC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SYNC;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== rtl/snp_packet_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// snp_packet_receiver_unit
// SNP packet receiver: takes one received byte per word, checks the 16-bit
// sum and emits one result word per payload byte (one if there is none), or a
// bad-checksum reply.
// Receive: one byte word per cycle while in_ready is high, including sync,
// header, data and checksum. After the checksum, each result takes a payload
// memory read, then an output register load that waits for a free output;
// in_ready stays low until the last result of the packet is loaded.
// Reset: configuration registers to defaults, parser hunting for sync,
// no result pending.
module snp_packet_receiver_unit import snp_rx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 status,
	output logic [7:0]           packet_type,
	output logic [7:0]           address,
	output logic [1:0]           address_class,
	output logic [LEN_W-1:0]     payload_len,
	output logic [LEN_W-1:0]     byte_index,
	output logic [7:0]           data_byte,
	output logic [15:0]          checksum,
	output logic                 last
);

	srx_cmd_t  cmd;
	srx_stat_t stat;

	snp_rx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	snp_rx_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.stat          (stat),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.status        (status),
		.packet_type   (packet_type),
		.address       (address),
		.address_class (address_class),
		.payload_len   (payload_len),
		.byte_index    (byte_index),
		.data_byte     (data_byte),
		.checksum      (checksum),
		.last          (last)
	);

endmodule
